// File: hdl/gra_pkg.sv
// Shared types and constants of the generational region allocator.
package gra_pkg;

  localparam logic [1:0]  OP_ALLOC     = 2'd0;
  localparam logic [1:0]  OP_CHECK     = 2'd1;
  localparam logic [1:0]  OP_FREE      = 2'd2;

  localparam logic [15:0] HEADER_BYTES = 16'd16;
  localparam logic [30:0] FIRST_GEN    = 31'd1;
  localparam logic [30:0] GEN_MAX      = 31'h7FFF_FFFF;
  localparam logic [15:0] CAP_RESET    = 16'd4096;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_STALE     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RES_PLAIN = 2'd0,
    RES_BUMP  = 2'd1,
    RES_REUSE = 2'd2
  } res_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOOKUP,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [31:0] gen;
    logic [15:0]        size;
    logic [15:0]        start;
  } entry_t;

  typedef struct packed {
    logic      capture;
    logic      bump_write;
    logic      free_write;
    logic      reuse_write;
    logic      lookup_issue;
    logic      scan_clear;
    logic      scan_issue;
    logic      res_load;
    res_kind_e res_kind;
    status_e   res_status;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bump_fits;
    logic       table_full;
    logic       idx_bad;
    logic       hneg;
    logic       stale;
    logic       scan_more;
    logic       hit;
    logic       out_free;
  } sts_t;

endpackage

// File: hdl/generational_region_allocator.sv
// Top level of the generational region allocator.
// Each item (alloc, check, free) yields one result item. A check or free that reads the
// block table passes S_DECODE, S_LOOKUP and S_DONE before the next item can be accepted.
// A bump alloc, a check with a negative handle, a bad index and an unknown operation
// skip S_LOOKUP. An alloc that does not fit behind the bump offset walks the block table
// in a RAM with one read port, one entry per cycle, in S_SCAN, up to block_count entries
// (at most MAX_BLOCKS). The result waits in an output register, so the next item is
// accepted while the previous result is still stalled. Only when a finished item finds
// that register still holding a stalled result does the item wait, for as long as the
// stall lasts.
module generational_region_allocator
  import gra_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        request_size_i,
  input  logic [5:0]         block_index_i,
  input  logic signed [31:0] handle_generation_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [5:0]         result_index_o,
  output logic [15:0]        data_offset_o,
  output logic [30:0]        result_generation_o
);

  cmd_t cmd;
  sts_t sts;

  gra_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gra_dp #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .operation_i        (operation_i),
    .request_size_i     (request_size_i),
    .block_index_i      (block_index_i),
    .handle_generation_i(handle_generation_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .result_index_o     (result_index_o),
    .data_offset_o      (data_offset_o),
    .result_generation_o(result_generation_o)
  );

  a_bump_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.bump_write |-> sts.bump_fits && !sts.table_full)
    else $error("bump write without room");

  a_reuse_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.reuse_write |-> sts.hit)
    else $error("reuse write without a fitting freed block");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.bump_write, cmd.reuse_write, cmd.free_write}))
    else $error("multiple table writes");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result overwrites an unread item");

endmodule

// File: hdl/gra_ram.sv
// Generic single-port-write, registered-read RAM.
module gra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/gra_ctrl.sv
// Sequencing state machine of the generational region allocator.
module gra_ctrl
  import gra_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_ALLOC: begin
            if (sts_i.bump_fits) begin
              cmd_o.res_load = 1'b1;
              if (sts_i.table_full) begin
                cmd_o.res_status = ST_NO_ROOM;
              end else begin
                cmd_o.bump_write = 1'b1;
                cmd_o.res_kind   = RES_BUMP;
              end
              state_d = S_DONE;
            end else begin
              cmd_o.scan_clear = 1'b1;
              state_d          = S_SCAN;
            end
          end
          OP_CHECK: begin
            if (sts_i.hneg) begin
              cmd_o.res_load = 1'b1;
              state_d        = S_DONE;
            end else if (sts_i.idx_bad) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_BAD_INDEX;
              state_d          = S_DONE;
            end else begin
              cmd_o.lookup_issue = 1'b1;
              state_d            = S_LOOKUP;
            end
          end
          OP_FREE: begin
            if (sts_i.idx_bad) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_BAD_INDEX;
              state_d          = S_DONE;
            end else begin
              cmd_o.lookup_issue = 1'b1;
              state_d            = S_LOOKUP;
            end
          end
          default: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_BAD_INDEX;
            state_d          = S_DONE;
          end
        endcase
      end
      S_LOOKUP: begin
        cmd_o.res_load = 1'b1;
        if (sts_i.op == OP_CHECK) begin
          cmd_o.res_status = sts_i.stale ? ST_STALE : ST_OK;
        end else if (!sts_i.hneg && sts_i.stale) begin
          cmd_o.res_status = ST_STALE;
        end else begin
          cmd_o.free_write = 1'b1;
        end
        state_d = S_DONE;
      end
      S_SCAN: begin
        priority if (sts_i.hit) begin
          cmd_o.reuse_write = 1'b1;
          cmd_o.res_load    = 1'b1;
          cmd_o.res_kind    = RES_REUSE;
          state_d           = S_DONE;
        end else if (!sts_i.scan_more) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NO_ROOM;
          state_d          = S_DONE;
        end else begin
          cmd_o.scan_issue = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/gra_dp.sv
// Datapath: item registers, bump state, block table, scan and result registers.
module gra_dp
  import gra_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        request_size_i,
  input  logic [5:0]         block_index_i,
  input  logic signed [31:0] handle_generation_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [5:0]         result_index_o,
  output logic [15:0]        data_offset_o,
  output logic [30:0]        result_generation_o
);

  localparam int AW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  logic [1:0]         op_q;
  logic [15:0]        req_q;
  logic [5:0]         idx_q;
  logic signed [31:0] hgen_q;
  logic [15:0]        cap_q;
  logic [15:0]        bump_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      scan_q;
  logic               rv_q;
  logic [AW-1:0]      rd_idx_q;

  logic [1:0]         res_status_q;
  logic [5:0]         res_index_q;
  logic [15:0]        res_offset_q;
  logic [30:0]        res_gen_q;
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [5:0]         out_index_q;
  logic [15:0]        out_offset_q;
  logic [30:0]        out_gen_q;

  logic [CMPW-1:0]    idx_ext;
  logic [CMPW-1:0]    count_ext;
  logic [CMPW-1:0]    rd_idx_ext;
  logic [AW-1:0]      idx_addr;
  logic [17:0]        bump_end;
  entry_t             ent;
  logic [$bits(entry_t)-1:0] rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        mag;
  logic [32:0]        ng;
  logic [30:0]        reuse_gen;

  assign idx_ext    = CMPW'(idx_q);
  assign count_ext  = CMPW'(count_q);
  assign rd_idx_ext = CMPW'(rd_idx_q);
  assign idx_addr   = idx_ext[AW-1:0];
  assign bump_end   = {2'b00, bump_q} + 18'(HEADER_BYTES) + {2'b00, req_q};
  assign ent        = entry_t'(rdata);

  assign mag       = 32'd0 - ent.gen;
  assign ng        = {1'b0, mag} + 33'd1;
  assign reuse_gen = (ng[32] || ng[31]) ? GEN_MAX : ng[30:0];

  assign sts_o.op         = op_q;
  assign sts_o.bump_fits  = (bump_end <= {2'b00, cap_q});
  assign sts_o.table_full = (count_q == CW'(MAX_BLOCKS));
  assign sts_o.idx_bad    = (idx_ext >= count_ext);
  assign sts_o.hneg       = hgen_q[31];
  assign sts_o.stale      = (hgen_q != ent.gen);
  assign sts_o.scan_more  = (scan_q < count_q);
  assign sts_o.hit        = rv_q && ent.gen[31] && (ent.size >= req_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign ram_re    = cmd_i.lookup_issue || cmd_i.scan_issue;
  assign ram_raddr = cmd_i.lookup_issue ? idx_addr : scan_q[AW-1:0];
  assign ram_we    = cmd_i.bump_write || cmd_i.reuse_write || cmd_i.free_write;

  always_comb begin
    ram_waddr = idx_addr;
    ram_wdata = ent;
    priority if (cmd_i.bump_write) begin
      ram_waddr       = count_q[AW-1:0];
      ram_wdata.gen   = {1'b0, FIRST_GEN};
      ram_wdata.size  = req_q;
      ram_wdata.start = bump_q;
    end else if (cmd_i.reuse_write) begin
      ram_waddr     = rd_idx_q;
      ram_wdata.gen = {1'b0, reuse_gen};
    end else begin
      ram_wdata.gen = 32'sd0 - ent.gen;
    end
  end

  gra_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  // item capture and scan read index
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      req_q  <= request_size_i;
      idx_q  <= block_index_i;
      hgen_q <= handle_generation_i;
    end
    if (cmd_i.scan_issue) begin
      rd_idx_q <= scan_q[AW-1:0];
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      bump_q  <= '0;
      count_q <= '0;
      scan_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.bump_write) begin
        bump_q  <= bump_end[15:0];
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.scan_clear) begin
        scan_q <= '0;
      end else if (cmd_i.scan_issue) begin
        scan_q <= scan_q + CW'(1);
      end
      rv_q <= cmd_i.scan_issue;
    end
  end

  // pending result and output result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      unique case (cmd_i.res_kind)
        RES_BUMP: begin
          res_index_q  <= count_ext[5:0];
          res_offset_q <= bump_q + HEADER_BYTES;
          res_gen_q    <= FIRST_GEN;
        end
        RES_REUSE: begin
          res_index_q  <= rd_idx_ext[5:0];
          res_offset_q <= ent.start + HEADER_BYTES;
          res_gen_q    <= reuse_gen;
        end
        default: begin
          res_index_q  <= '0;
          res_offset_q <= '0;
          res_gen_q    <= '0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_offset_q <= res_offset_q;
      out_gen_q    <= res_gen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign result_index_o      = out_index_q;
  assign data_offset_o       = out_offset_q;
  assign result_generation_o = out_gen_q;

endmodule

// File: dv/tb_generational_region_allocator.sv
`timescale 1ns / 100ps
// Testbench of the generational region allocator: directed table, then random handle traffic.
module tb_generational_region_allocator;
  import gra_pkg::*;

  localparam int         MAX_SLOTS  = 64;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef struct packed {
    status_e     st;
    logic [5:0]  idx;
    logic [15:0] off;
    logic [30:0] gen;
  } alloc_result_t;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         op;
    logic [15:0]        req;
    logic [5:0]         idx;
    logic signed [31:0] hgen;
    bit                 typed;
    alloc_result_t      want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i = OP_ALLOC;
  logic [15:0]        request_size_i = 16'd0;
  logic [5:0]         block_index_i = 6'd0;
  logic signed [31:0] handle_generation_i = 32'sd0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i = 16'd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [5:0]         result_index_o;
  logic [15:0]        data_offset_o;
  logic [30:0]        result_generation_o;

  bit                 given_typed = 1'b0;
  alloc_result_t      given_result = '0;

  int                 send_gap_pct = 0;
  int                 sink_stall_pct = 0;
  int                 fail_count = 0;

  // predictor state
  logic [15:0]        pred_capacity = CAP_RESET;
  logic [15:0]        pred_bump = 16'd0;
  logic [6:0]         pred_count = 7'd0;
  logic signed [31:0] pred_gen [MAX_SLOTS];
  logic [15:0]        pred_size [MAX_SLOTS];
  logic [15:0]        pred_start [MAX_SLOTS];

  alloc_result_t      pending_results [$];
  dir_row_t           dir_rows [$];

  generational_region_allocator dut (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .request_size_i     (request_size_i),
    .block_index_i      (block_index_i),
    .handle_generation_i(handle_generation_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .result_index_o     (result_index_o),
    .data_offset_o      (data_offset_o),
    .result_generation_o(result_generation_o)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall_i <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
  end

  function automatic alloc_result_t region_next_result(input logic [1:0] op,
      input logic [15:0] req, input logic [5:0] idx, input logic signed [31:0] hgen);
    alloc_result_t res;
    longint        ng;
    bit            found;
    res = '0;
    res.st = ST_OK;
    found = 1'b0;
    case (op)
      OP_ALLOC: begin
        if (int'(pred_bump) + int'(HEADER_BYTES) + int'(req) <= int'(pred_capacity)) begin
          if (pred_count >= MAX_SLOTS) begin
            res.st = ST_NO_ROOM;
          end else begin
            pred_start[pred_count] = pred_bump;
            pred_size[pred_count] = req;
            pred_gen[pred_count] = 32'sd1;
            res.idx = pred_count[5:0];
            res.off = pred_bump + HEADER_BYTES;
            res.gen = FIRST_GEN;
            pred_bump = pred_bump + HEADER_BYTES + req;
            pred_count = pred_count + 7'd1;
          end
        end else begin
          res.st = ST_NO_ROOM;
          for (int i = 0; i < pred_count; i++) begin
            if (!found && pred_gen[i] < 0 && pred_size[i] >= req) begin
              found = 1'b1;
              ng = -longint'(pred_gen[i]) + 1;
              if (ng > longint'(GEN_MAX)) ng = longint'(GEN_MAX);
              pred_gen[i] = ng[31:0];
              res.st = ST_OK;
              res.idx = i[5:0];
              res.off = pred_start[i] + HEADER_BYTES;
              res.gen = ng[30:0];
            end
          end
        end
      end
      OP_CHECK: begin
        if (hgen < 0) res.st = ST_OK;
        else if (idx >= pred_count) res.st = ST_BAD_INDEX;
        else if (hgen != pred_gen[idx]) res.st = ST_STALE;
      end
      OP_FREE: begin
        if (idx >= pred_count) res.st = ST_BAD_INDEX;
        else if (hgen >= 0 && hgen != pred_gen[idx]) res.st = ST_STALE;
        else pred_gen[idx] = -pred_gen[idx];
      end
      default: res.st = ST_BAD_INDEX;
    endcase
    return res;
  endfunction

  task automatic note_mismatch(input string what, input alloc_result_t want,
      input alloc_result_t got);
    if (fail_count < 10) begin
      $display("%0t %s: expected st=%0d idx=%0d off=%0d gen=%0d, got st=%0d idx=%0d off=%0d gen=%0d",
               $realtime, what, want.st, want.idx, want.off, want.gen,
               got.st, got.idx, got.off, got.gen);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    alloc_result_t got;
    alloc_result_t want;
    alloc_result_t pred;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.st  = status_e'(status_o);
        got.idx = result_index_o;
        got.off = data_offset_o;
        got.gen = result_generation_o;
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
      if (cfg_valid_i && cfg_ready_o) pred_capacity = cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        pred = region_next_result(operation_i, request_size_i, block_index_i,
                                  handle_generation_i);
        pending_results.push_back(given_typed ? given_result : pred);
      end
    end
  end

  // called right after a falling edge
  task automatic drive_item(input logic [1:0] op, input logic [15:0] req,
      input logic [5:0] idx, input logic signed [31:0] hgen, input bit typed,
      input alloc_result_t want);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i          <= 1'b1;
    operation_i         <= op;
    request_size_i      <= req;
    block_index_i       <= idx;
    handle_generation_i <= hgen;
    given_typed         <= typed;
    given_result        <= want;
    do @(posedge clk); while (in_stall_o);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    wait_drained();
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    logic [1:0]         op;
    logic [15:0]        req;
    logic [5:0]         idx;
    logic signed [31:0] hgen;
    int                 pick;
    int                 k;
    @(negedge clk);
    op   = 2'($urandom_range(3));
    req  = 16'($urandom);
    idx  = 6'($urandom);
    hgen = $urandom;
    pick = $urandom_range(99);
    if (pick < 38) begin
      op = OP_ALLOC;
      k = $urandom_range(99);
      if (k < 60) req = 16'($urandom_range(63));
      else if (k < 85) req = 16'($urandom_range(511));
      else if (k > 95) req = 16'hFFFF;
    end else if (pick < 90) begin
      op = (pick < 64) ? OP_CHECK : OP_FREE;
      if (pred_count != 0 && $urandom_range(9) < 8) idx = 6'($urandom_range(pred_count - 1));
      k = $urandom_range(9);
      if (idx < pred_count && k < 6) hgen = pred_gen[idx];
      else if (idx < pred_count && k == 6) hgen = pred_gen[idx] + 32'sd1;
      else if (k == 7) hgen = -$signed({1'b0, 31'($urandom_range(1000))}) - 32'sd1;
    end
    if (hgen == 32'sh8000_0000) hgen = -32'sd1;
    drive_item(op, req, idx, hgen, 1'b0, '0);
  endtask

  function automatic dir_row_t row(input bit is_cfg, input logic [1:0] op,
      input logic [15:0] req, input logic [5:0] idx, input logic signed [31:0] hgen,
      input bit typed, input status_e st, input logic [5:0] ridx, input logic [15:0] off,
      input logic [30:0] gen);
    dir_row_t r;
    r.is_cfg = is_cfg;
    r.op = op;
    r.req = req;
    r.idx = idx;
    r.hgen = hgen;
    r.typed = typed;
    r.want.st = st;
    r.want.idx = ridx;
    r.want.off = off;
    r.want.gen = gen;
    return r;
  endfunction

  initial begin
    dir_row_t r;
    logic [15:0] cap;
    // empty table: bad index, negative handles pass, unknown op
    dir_rows.push_back(row(0, OP_CHECK, 16'd0, 6'd0, 32'sd5, 1, ST_BAD_INDEX, 0, 0, 0));
    dir_rows.push_back(row(0, OP_FREE, 16'hFFFF, 6'd63, 32'sd0, 1, ST_BAD_INDEX, 0, 0, 0));
    dir_rows.push_back(row(0, OP_CHECK, 16'd0, 6'd63, -32'sd1, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_CHECK, 16'd0, 6'd5, -32'sd2147483647, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_UNKNOWN, 16'hFFFF, 6'd63, 32'sd2147483647, 1,
                           ST_BAD_INDEX, 0, 0, 0));
    // bump allocs, checks and frees of them, and an alloc that finds no room
    dir_rows.push_back(row(0, OP_ALLOC, 16'd0, 6'd0, 32'sd0, 1, ST_OK, 6'd0, 16'd16, 31'd1));
    dir_rows.push_back(row(0, OP_ALLOC, 16'd100, 6'd63, -32'sd1, 1, ST_OK, 6'd1, 16'd32, 31'd1));
    dir_rows.push_back(row(0, OP_CHECK, 16'd0, 6'd1, 32'sd1, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_CHECK, 16'd0, 6'd1, 32'sd2147483647, 1, ST_STALE, 0, 0, 0));
    dir_rows.push_back(row(0, OP_FREE, 16'd0, 6'd0, 32'sd7, 1, ST_STALE, 0, 0, 0));
    dir_rows.push_back(row(0, OP_FREE, 16'd0, 6'd0, 32'sd1, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_CHECK, 16'd0, 6'd0, 32'sd1, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_ALLOC, 16'hFFFF, 6'd0, 32'sd0, 1, ST_NO_ROOM, 0, 0, 0));
    // zero, then full capacity: every alloc goes to the freed-block search
    dir_rows.push_back(row(1, OP_ALLOC, 16'd0, 6'd0, 32'sd0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_ALLOC, 16'd0, 6'd0, 32'sd0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_ALLOC, 16'd0, 6'd0, 32'sd0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_FREE, 16'd0, 6'd0, -32'sd5, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_FREE, 16'd0, 6'd0, -32'sd5, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_FREE, 16'd0, 6'd1, 32'sd1, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_ALLOC, 16'd101, 6'd0, 32'sd0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_ALLOC, 16'd100, 6'd0, 32'sd0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_CHECK, 16'd0, 6'd1, 32'sd2, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(1, OP_ALLOC, 16'hFFFF, 6'd0, 32'sd0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(row(0, OP_ALLOC, 16'hFFFF, 6'd0, 32'sd0, 0, ST_OK, 0, 0, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (dir_rows[n]) begin
      r = dir_rows[n];
      if (r.is_cfg) begin
        write_capacity(r.req);
      end else begin
        @(negedge clk);
        drive_item(r.op, r.req, r.idx, r.hgen, r.typed, r.want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cap = CAP_RESET;
        1: cap = 16'd600;
        2: cap = 16'hFFFF;
        3: cap = 16'd0;
        4: cap = 16'd2000;
        5: cap = 16'($urandom);
        6: cap = 16'd300;
        default: cap = 16'hFFFF;
      endcase
      write_capacity(cap);
      case (ph % 4)
        0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_gap_pct = 53; sink_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  sink_stall_pct = 53; end
        default: begin send_gap_pct = 28; sink_stall_pct = 28; end
      endcase
      repeat (128) random_item();
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
